// ===== src/scs_pkg.sv =====
package scs_pkg;

    localparam int SCS_CHANNELS = 4;
    localparam int SCS_WINDOW   = 8;
    localparam int SCS_SLOT_W   = $clog2(SCS_WINDOW);
    localparam int SCS_SUM_W    = 16 + SCS_SLOT_W;
    localparam int SCS_FS_W     = 17;
    localparam int SCS_PROD_W   = SCS_FS_W + 16;
    localparam int SCS_ADDR_W   = 3;

    localparam logic [SCS_FS_W-1:0] SCS_FS_RESET = SCS_FS_W'(50000);

    typedef enum logic
    {
        REG_FULL_SCALE = 1'b0,
        REG_NONE       = 1'b1
    } scs_reg_t;

    typedef struct packed
    {
        logic [15:0] raw_ch0;
        logic [15:0] raw_ch1;
        logic [15:0] raw_ch2;
        logic [15:0] raw_ch3;
        logic        bidir_ch0;
        logic        bidir_ch1;
        logic        bidir_ch2;
        logic        bidir_ch3;
    } scs_in_t;

    typedef struct packed
    {
        logic signed [15:0] avg_ma_ch0;
        logic signed [15:0] avg_ma_ch1;
        logic signed [15:0] avg_ma_ch2;
        logic signed [15:0] avg_ma_ch3;
    } scs_out_t;

    typedef struct packed
    {
        logic load_mul;
        logic load_sat;
        logic load_out;
    } scs_ctrl_t;

endpackage

// ===== src/scs_scale.sv =====
module scs_scale
(
    input  logic                            clk,
    input  scs_pkg::scs_ctrl_t              ctrl,
    input  logic [15:0]                     raw,
    input  logic                            bidir,
    input  logic [scs_pkg::SCS_FS_W-1:0]    full_scale,
    output logic signed [15:0]              sample
);
    import scs_pkg::*;

    logic [15:0]            mag;
    logic [SCS_PROD_W-1:0]  prod_reg;
    logic                   neg_reg;
    logic                   bidir_reg;
    logic [17:0]            quot;
    logic [17:0]            quot_neg;
    logic signed [15:0]     sample_next;
    logic signed [15:0]     sample_reg;

    assign mag = (bidir && raw[15]) ? (16'd0 - raw) : raw;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            prod_reg  <= SCS_PROD_W'(full_scale) * SCS_PROD_W'(mag);
            neg_reg   <= bidir && raw[15];
            bidir_reg <= bidir;
        end
    end

    // signed readings scale by 2^-15, unsigned by 2^-16
    assign quot     = bidir_reg ? prod_reg[SCS_PROD_W-1:15] : {1'b0, prod_reg[SCS_PROD_W-1:16]};
    assign quot_neg = 18'd0 - quot;

    always_comb
    begin
        if (neg_reg)
        begin
            sample_next = (quot > 18'd32768) ? 16'sh8000 : $signed(quot_neg[15:0]);
        end
        else
        begin
            sample_next = (quot > 18'd32767) ? 16'sh7fff : $signed(quot[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sat)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

// ===== src/scs_window.sv =====
module scs_window
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  scs_pkg::scs_ctrl_t                  ctrl,
    input  logic [scs_pkg::SCS_SLOT_W-1:0]      slot,
    input  logic signed [15:0]                  sample,
    output logic signed [15:0]                  avg
);
    import scs_pkg::*;

    logic signed [15:0]             ring_reg [SCS_WINDOW];
    logic signed [SCS_SUM_W-1:0]    sum_reg;
    logic signed [SCS_SUM_W-1:0]    sum_next;
    logic signed [SCS_SUM_W-1:0]    biased;
    logic signed [SCS_SUM_W-1:0]    quot;

    assign sum_next = sum_reg
                    - {{(SCS_SUM_W-16){ring_reg[slot][15]}}, ring_reg[slot]}
                    + {{(SCS_SUM_W-16){sample[15]}}, sample};

    // truncate toward zero: bias negative sums before the shift
    assign biased = sum_next + (sum_next[SCS_SUM_W-1] ? SCS_SUM_W'(SCS_WINDOW - 1)
                                                      : SCS_SUM_W'(0));
    assign quot   = biased >>> SCS_SLOT_W;
    assign avg    = quot[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < SCS_WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (ctrl.load_out)
        begin
            sum_reg        <= sum_next;
            ring_reg[slot] <= sample;
        end
    end

endmodule

// ===== src/shunt_current_scale_average.sv =====
// Four-channel shunt current scaler with an eight-sample moving average.
//
// Input channel (in_valid / in_stall / in_data): one transfer carries a raw
// 16-bit reading and a bidirectional flag for each of the four channels.
// Output channel (out_valid / out_stall / out_data): one transfer per input
// transfer, holding the signed milliamp window average of each channel.
// Configuration: APB-style port, one register at byte address 0 holding the
// full scale current (17 bits); pready is always high.
//
// From input transfer to output valid, data passes the multiplier register,
// the saturation register, then the running-sum update that loads the
// output register. Throughput is one transfer per cycle while out_stall is
// low, set by the 17x16 multiplier stage and the per-lane running-sum update.
// Each stage holds its data independently, so the block keeps accepting
// input while a result waits, until all three stages are full.
//
// Reset clears the sample rings, running sums and slot pointer to zero and
// loads full scale with 50000 mA. The output holds while stalled and valid.
module shunt_current_scale_average
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scs_pkg::SCS_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  scs_pkg::scs_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output scs_pkg::scs_out_t                   out_data
);
    import scs_pkg::*;

    logic [SCS_FS_W-1:0]    full_scale_reg;
    logic                   mul_valid_reg;
    logic                   sat_valid_reg;
    logic                   out_valid_reg;
    logic [SCS_SLOT_W-1:0]  slot_reg;
    scs_out_t               out_data_reg;
    scs_ctrl_t              ctrl;
    logic                   en_mul;
    logic                   en_sat;
    logic                   en_out;
    scs_reg_t               reg_sel;

    logic [15:0]            raw     [SCS_CHANNELS];
    logic                   bidir   [SCS_CHANNELS];
    logic signed [15:0]     sample  [SCS_CHANNELS];
    logic signed [15:0]     avg     [SCS_CHANNELS];

    // configuration
    assign reg_sel = scs_reg_t'(paddr[2]);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_sel)
            REG_FULL_SCALE: prdata = 32'(full_scale_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= SCS_FS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel == REG_FULL_SCALE)
        begin
            full_scale_reg <= pwdata[SCS_FS_W-1:0];
        end
    end

    // pipeline flow control
    assign en_out = !out_valid_reg || !out_stall;
    assign en_sat = !sat_valid_reg || en_out;
    assign en_mul = !mul_valid_reg || en_sat;

    assign ctrl.load_mul = en_mul && in_valid;
    assign ctrl.load_sat = en_sat && mul_valid_reg;
    assign ctrl.load_out = en_out && sat_valid_reg;

    assign in_stall = !en_mul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sat_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            if (en_mul)
            begin
                mul_valid_reg <= in_valid;
            end
            if (en_sat)
            begin
                sat_valid_reg <= mul_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= sat_valid_reg;
            end
            if (ctrl.load_out)
            begin
                slot_reg <= SCS_SLOT_W'(slot_reg + 1'b1);
            end
        end
    end

    // lanes
    assign raw[0]   = in_data.raw_ch0;
    assign raw[1]   = in_data.raw_ch1;
    assign raw[2]   = in_data.raw_ch2;
    assign raw[3]   = in_data.raw_ch3;
    assign bidir[0] = in_data.bidir_ch0;
    assign bidir[1] = in_data.bidir_ch1;
    assign bidir[2] = in_data.bidir_ch2;
    assign bidir[3] = in_data.bidir_ch3;

    for (genvar c = 0; c < SCS_CHANNELS; c++)
    begin : g_lane
        scs_scale u_scale
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .raw        (raw[c]),
            .bidir      (bidir[c]),
            .full_scale (full_scale_reg),
            .sample     (sample[c])
        );

        scs_window u_window
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .slot   (slot_reg),
            .sample (sample[c]),
            .avg    (avg[c])
        );
    end

    // merge lanes into the output register
    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg.avg_ma_ch0 <= avg[0];
            out_data_reg.avg_ma_ch1 <= avg[1];
            out_data_reg.avg_ma_ch2 <= avg[2];
            out_data_reg.avg_ma_ch3 <= avg[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/scs_checker.sv =====
module scs_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scs_pkg::SCS_ADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    input  logic [31:0]                         prdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  scs_pkg::scs_in_t                    in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  scs_pkg::scs_out_t                   out_data
);
    import scs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output data changed while stalled");

    // input backs up only once the output side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // an accepted transfer reaches out_valid when the output is not stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("result missing three cycles after transfer");

endmodule

bind shunt_current_scale_average scs_checker u_scs_checker (.*);

// ===== verif/shunt_current_scale_average_tb.sv =====
`timescale 1ns / 1ps

module shunt_current_scale_average_tb;

    import scs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 64;
    localparam logic [SCS_ADDR_W-1:0] FULL_SCALE_ADDR = SCS_ADDR_W'(4 * int'(REG_FULL_SCALE));

    class avg_scoreboard;
        logic signed [15:0]          ring [SCS_WINDOW][SCS_CHANNELS];
        logic [SCS_SLOT_W-1:0]       slot;
        logic signed [SCS_SUM_W-1:0] sums [SCS_CHANNELS];
        logic [SCS_FS_W-1:0]         full_scale;
        scs_out_t                    expected_avgs [$];
        int                          errors;

        function new();
            for (int s = 0; s < SCS_WINDOW; s++)
            begin
                for (int c = 0; c < SCS_CHANNELS; c++)
                begin
                    ring[s][c] = '0;
                end
            end
            for (int c = 0; c < SCS_CHANNELS; c++)
            begin
                sums[c] = '0;
            end
            slot       = '0;
            full_scale = SCS_FS_RESET;
            errors     = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] avg check: %s", $realtime, msg);
            errors++;
        endtask

        // milliamps from one raw reading, truncated toward zero, saturated
        function logic signed [15:0] scale_ma(input logic [15:0] raw, input logic bidir);
            longint unsigned mag;
            longint unsigned q;
            bit              neg;
            neg = 1'b0;
            if (bidir)
            begin
                if (raw[15])
                begin
                    neg = 1'b1;
                    mag = 64'h10000 - 64'(raw);
                end
                else
                begin
                    mag = 64'(raw);
                end
                q = (64'(full_scale) * mag) >> 15;
            end
            else
            begin
                q = (64'(full_scale) * 64'(raw)) >> 16;
            end
            if (neg)
            begin
                if (q > 64'd32768)
                    q = 64'd32768;
                return 16'(64'd0 - q);
            end
            if (q > 64'd32767)
                q = 64'd32767;
            return 16'(q);
        endfunction

        function int pending();
            return expected_avgs.size();
        endfunction

        function void note_input(input scs_in_t d);
            logic [15:0]        raws   [SCS_CHANNELS];
            logic               bidirs [SCS_CHANNELS];
            logic signed [15:0] avgs   [SCS_CHANNELS];
            logic signed [15:0] sample;
            scs_out_t           e;
            raws   = '{d.raw_ch0, d.raw_ch1, d.raw_ch2, d.raw_ch3};
            bidirs = '{d.bidir_ch0, d.bidir_ch1, d.bidir_ch2, d.bidir_ch3};
            for (int c = 0; c < SCS_CHANNELS; c++)
            begin
                sample        = scale_ma(raws[c], bidirs[c]);
                sums[c]       = sums[c] - ring[slot][c] + sample;
                ring[slot][c] = sample;
                avgs[c]       = 16'(int'(sums[c]) / SCS_WINDOW);
            end
            slot = slot + 1'b1;
            e.avg_ma_ch0 = avgs[0];
            e.avg_ma_ch1 = avgs[1];
            e.avg_ma_ch2 = avgs[2];
            e.avg_ma_ch3 = avgs[3];
            expected_avgs.push_back(e);
        endfunction

        task check_result(input scs_out_t got);
            scs_out_t           e;
            logic signed [15:0] want [SCS_CHANNELS];
            logic signed [15:0] seen [SCS_CHANNELS];
            if (expected_avgs.size() == 0)
            begin
                report("result transfer with nothing expected");
                return;
            end
            e    = expected_avgs.pop_front();
            want = '{e.avg_ma_ch0, e.avg_ma_ch1, e.avg_ma_ch2, e.avg_ma_ch3};
            seen = '{got.avg_ma_ch0, got.avg_ma_ch1, got.avg_ma_ch2, got.avg_ma_ch3};
            for (int c = 0; c < SCS_CHANNELS; c++)
            begin
                if (seen[c] !== want[c])
                    report($sformatf("avg_ma_ch%0d expected %0d got %0d", c, want[c], seen[c]));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [SCS_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    scs_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    scs_out_t    out_data;

    avg_scoreboard avg_board = new();

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit pressure_req = 1'b0;
    bit pressure_taken = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    shunt_current_scale_average dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                avg_board.note_input(in_data);
            if (out_valid && !out_stall)
                avg_board.check_result(out_data);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (pressure_req && !pressure_taken)
        begin
            pressure_taken = 1'b1;
            hold_left      = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_idle_en)
        begin
            out_stall <= ($urandom_range(99) < 10);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic scs_in_t make_item(input logic [15:0] r0, input logic [15:0] r1,
                                          input logic [15:0] r2, input logic [15:0] r3,
                                          input logic [3:0] bd);
        scs_in_t d;
        d.raw_ch0   = r0;
        d.raw_ch1   = r1;
        d.raw_ch2   = r2;
        d.raw_ch3   = r3;
        d.bidir_ch0 = bd[0];
        d.bidir_ch1 = bd[1];
        d.bidir_ch2 = bd[2];
        d.bidir_ch3 = bd[3];
        return d;
    endfunction

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input scs_in_t d);
        if (tx_idle_en && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_item(make_item(rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                                4'($urandom)));
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (avg_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_full_scale(input logic [SCS_FS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FULL_SCALE_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        avg_board.full_scale = value;
    endtask

    task automatic run_directed();
        // startup window still holds zeros
        send_item(make_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b0000));
        send_item(make_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b1111));
        send_item(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0000));
        send_item(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111));
        send_item(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'b0000));
        send_item(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'b1111));
        send_item(make_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'b0000));
        send_item(make_item(16'h0001, 16'h0001, 16'h0001, 16'h0001, 4'b1111));
        send_item(make_item(16'h0001, 16'h0001, 16'h0001, 16'h0001, 4'b0000));
        send_item(make_item(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 4'b1010));
        send_item(make_item(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 4'b0101));
        send_item(make_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'b0011));
        // full window of most negative readings saturates the average
        for (int i = 0; i < 8; i++)
        begin
            send_item(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'b1111));
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(120);
        drain();

        write_full_scale(17'd1);
        run_random(100);
        drain();

        write_full_scale(17'd100000);
        tx_idle_en = 1'b0;
        pressure_req <= 1'b1;
        run_random(120);
        drain();

        write_full_scale(17'd131071);
        rx_idle_en <= 1'b0;
        run_random(100);
        drain();

        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        write_full_scale(17'd0);
        run_random(60);
        drain();

        write_full_scale(17'($urandom_range(1, 100000)));
        run_random(150);
        drain();

        write_full_scale(17'($urandom_range(0, 131071)));
        run_random(150);
        drain();

        if (avg_board.pending() != 0)
            avg_board.report($sformatf("%0d results never arrived", avg_board.pending()));

        if (avg_board.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
